>>> hw/rtl/isu_pkg.sv
// ----------------------------------------------------------------------------
// isu_pkg
// Shared types and constants for the 1D Ising spin update unit.
// ----------------------------------------------------------------------------
`default_nettype none

package isu_pkg;

  localparam int SITE_W     = 10;
  localparam int COUNT_W    = 11;
  localparam int RAND_W     = 32;
  localparam int THR_W      = 33;
  localparam int SUM_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 33;

  localparam logic [THR_W-1:0]   THR_SAT   = 33'h1_0000_0000;
  localparam logic [COUNT_W-1:0] MIN_SPINS = 11'd3;
  localparam int                 DEF_SPINS = 1024;

  // neighbour sum -2 / 0 / +2 as a table column
  localparam logic [1:0] NBR_MINUS2 = 2'd0;
  localparam logic [1:0] NBR_ZERO   = 2'd1;
  localparam logic [1:0] NBR_PLUS2  = 2'd2;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_WRITE  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USE_METROPOLIS = 3'd0,
    REG_SPIN_COUNT     = 3'd1,
    REG_THR_UP_M2      = 3'd2,
    REG_THR_UP_Z       = 3'd3,
    REG_THR_UP_P2      = 3'd4,
    REG_THR_DN_M2      = 3'd5,
    REG_THR_DN_Z       = 3'd6,
    REG_THR_DN_P2      = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic              operation;
    logic [SITE_W-1:0] site;
    logic [RAND_W-1:0] random_fraction;
    logic              spin_value;
  } item_t;

  typedef struct packed {
    logic                    spin_after;
    logic                    changed;
    logic                    site_error;
    logic signed [SUM_W-1:0] magnetization;
    logic signed [SUM_W-1:0] bond_sum;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // thr[current spin is +1][neighbour sum column]
  typedef struct packed {
    logic                          use_metropolis;
    logic [COUNT_W-1:0]            spin_count;
    logic [1:0][2:0][THR_W-1:0]    thr;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic restart;
  } fill_t;

  typedef struct packed {
    logic                    spin_new;
    logic                    changed;
    logic signed [SUM_W-1:0] mag_delta;
    logic signed [SUM_W-1:0] bond_delta;
  } dec_t;

endpackage

`default_nettype wire

>>> hw/rtl/isu_stream_if.sv
// ----------------------------------------------------------------------------
// isu_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface isu_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/isu_spin_ram.sv
// ----------------------------------------------------------------------------
// isu_spin_ram
// One-bit spin memory: one write port, one registered read port, write-first.
// ----------------------------------------------------------------------------
`default_nettype none

module isu_spin_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic          wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output      logic          rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/isu_cfg_regs.sv
// ----------------------------------------------------------------------------
// isu_cfg_regs
// Configuration registers and the ring fill sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module isu_cfg_regs #(
  parameter int MAX_SPINS = 1024,
  parameter int AW        = $clog2(MAX_SPINS)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  isu_stream_if.sink         cfg,
  output isu_pkg::cfg_t      regs,
  output isu_pkg::fill_t     fill,
  output      logic [AW-1:0] fill_addr
);

  localparam logic [isu_pkg::COUNT_W-1:0] RESET_COUNT =
    isu_pkg::COUNT_W'((MAX_SPINS < isu_pkg::DEF_SPINS) ? MAX_SPINS : isu_pkg::DEF_SPINS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SPINS - 1);

  logic [isu_pkg::COUNT_W-1:0] cnt_raw;
  logic [isu_pkg::COUNT_W-1:0] cnt_clamped;
  logic [isu_pkg::THR_W-1:0]   thr_in;

  assign cfg.ready = 1'b1;
  assign cnt_raw   = cfg.payload.data[isu_pkg::COUNT_W-1:0];

  always_comb begin
    if (cnt_raw < isu_pkg::MIN_SPINS) begin
      cnt_clamped = isu_pkg::MIN_SPINS;
    end else if (32'(cnt_raw) > 32'(MAX_SPINS)) begin
      cnt_clamped = isu_pkg::COUNT_W'(MAX_SPINS);
    end else begin
      cnt_clamped = cnt_raw;
    end
  end

  // anything above 2^32 saturates
  assign thr_in = (cfg.payload.data[isu_pkg::THR_W-1] && (|cfg.payload.data[isu_pkg::RAND_W-1:0]))
                  ? isu_pkg::THR_SAT : cfg.payload.data[isu_pkg::THR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.use_metropolis <= 1'b1;
      regs.spin_count     <= RESET_COUNT;
      regs.thr            <= {6{isu_pkg::THR_SAT}};
      fill.busy           <= 1'b1;
      fill.restart        <= 1'b0;
      fill_addr           <= '0;
    end else begin
      fill.restart <= 1'b0;
      if (fill.busy) begin
        if (fill_addr == LAST_ADDR) begin
          fill.busy <= 1'b0;
        end else begin
          fill_addr <= fill_addr + 1'b1;
        end
      end
      if (cfg.valid) begin
        case (cfg.payload.index)
          isu_pkg::REG_USE_METROPOLIS: regs.use_metropolis <= cfg.payload.data[0];
          isu_pkg::REG_SPIN_COUNT: begin
            regs.spin_count <= cnt_clamped;
            fill.busy       <= 1'b1;
            fill.restart    <= 1'b1;
            fill_addr       <= '0;
          end
          isu_pkg::REG_THR_UP_M2: regs.thr[1][isu_pkg::NBR_MINUS2] <= thr_in;
          isu_pkg::REG_THR_UP_Z:  regs.thr[1][isu_pkg::NBR_ZERO]   <= thr_in;
          isu_pkg::REG_THR_UP_P2: regs.thr[1][isu_pkg::NBR_PLUS2]  <= thr_in;
          isu_pkg::REG_THR_DN_M2: regs.thr[0][isu_pkg::NBR_MINUS2] <= thr_in;
          isu_pkg::REG_THR_DN_Z:  regs.thr[0][isu_pkg::NBR_ZERO]   <= thr_in;
          isu_pkg::REG_THR_DN_P2: regs.thr[0][isu_pkg::NBR_PLUS2]  <= thr_in;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/isu_decide.sv
// ----------------------------------------------------------------------------
// isu_decide
// Metropolis / heat-bath decision for one site and the resulting sum deltas.
// ----------------------------------------------------------------------------
`default_nettype none

module isu_decide (
  input  wire logic                         op_write,
  input  wire logic [isu_pkg::RAND_W-1:0]   rnd,
  input  wire logic                         wval,
  input  wire logic                         spin_l,
  input  wire logic                         spin_c,
  input  wire logic                         spin_r,
  input  wire isu_pkg::cfg_t                regs,
  output      isu_pkg::dec_t                dec
);

  localparam logic signed [isu_pkg::SUM_W-1:0] D2 = isu_pkg::SUM_W'(2);
  localparam logic signed [isu_pkg::SUM_W-1:0] D4 = isu_pkg::SUM_W'(4);

  logic [1:0]                nbr_idx;
  logic [isu_pkg::THR_W-1:0] thr;
  logic [isu_pkg::THR_W-1:0] rnd_ext;
  logic                      spin_new;

  // count of +1 neighbours maps straight onto the column
  assign nbr_idx = {1'b0, spin_l} + {1'b0, spin_r};
  assign thr     = regs.thr[spin_c][nbr_idx];
  assign rnd_ext = {1'b0, rnd};

  always_comb begin
    if (op_write) begin
      spin_new = wval;
    end else if (regs.use_metropolis) begin
      spin_new = (rnd_ext <= thr) ? ~spin_c : spin_c;
    end else begin
      spin_new = (rnd_ext < thr);
    end
  end

  always_comb begin
    dec.spin_new   = spin_new;
    dec.changed    = (spin_new != spin_c);
    dec.mag_delta  = '0;
    dec.bond_delta = '0;
    if (dec.changed) begin
      dec.mag_delta = spin_new ? D2 : -D2;
      if (nbr_idx != isu_pkg::NBR_ZERO) begin
        dec.bond_delta = (spin_new == (nbr_idx == isu_pkg::NBR_PLUS2)) ? D4 : -D4;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ising_1d_spin_update_unit.sv
// Throughput: one item per cycle unless a fill pass or a stalled output holds items off; spin
// reads go to three copies of the ring memory.
// Reset: control and sums take their reset values at once, then a fill pass over all MAX_SPINS
// addresses sets every spin to +1 with items held off; each spin_count write starts the same pass.
// ----------------------------------------------------------------------------
// ising_1d_spin_update_unit
// Periodic 1D Ising ring with single-site Metropolis / heat-bath updates.
// ----------------------------------------------------------------------------
`default_nettype none

module ising_1d_spin_update_unit #(
  parameter int MAX_SPINS = 1024
) (
  input  wire logic    clk,
  input  wire logic    rst,
  isu_stream_if.sink   items,
  isu_stream_if.source results,
  isu_stream_if.sink   cfg
);

  localparam int AW = $clog2(MAX_SPINS);
  localparam logic signed [isu_pkg::SUM_W-1:0] RESET_SUM =
    isu_pkg::SUM_W'((MAX_SPINS < isu_pkg::DEF_SPINS) ? MAX_SPINS : isu_pkg::DEF_SPINS);

  isu_pkg::cfg_t  regs;
  isu_pkg::fill_t fill;
  logic [AW-1:0]  fill_addr;

  isu_cfg_regs #(.MAX_SPINS(MAX_SPINS), .AW(AW)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .regs      (regs),
    .fill      (fill),
    .fill_addr (fill_addr)
  );

  // accept side: neighbour addresses around the ring
  logic                        item_acc;
  logic [isu_pkg::COUNT_W-1:0] site_w;
  logic [isu_pkg::COUNT_W-1:0] left_w;
  logic [isu_pkg::COUNT_W-1:0] right_w;
  logic [isu_pkg::COUNT_W-1:0] site_inc;

  assign item_acc = items.valid && items.ready;
  assign site_w   = {1'b0, items.payload.site};
  assign site_inc = site_w + 1'b1;
  assign left_w   = (site_w == '0) ? regs.spin_count - 1'b1 : site_w - 1'b1;
  assign right_w  = (site_inc == regs.spin_count) ? '0 : site_inc;

  // stage 1: item with its three spins
  logic                       s1_valid;
  logic                       s1_adv;
  logic                       s1_write;
  logic                       s1_err;
  logic [isu_pkg::RAND_W-1:0] s1_rnd;
  logic                       s1_wval;
  logic [AW-1:0]              s1_site;
  logic                       spin_l;
  logic                       spin_c;
  logic                       spin_r;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic                       ram_wdata;

  isu_pkg::dec_t              dec;

  isu_spin_ram #(.DEPTH(MAX_SPINS), .AW(AW)) u_ram_l (
    .clk (clk), .we (ram_we), .waddr (ram_waddr), .wdata (ram_wdata),
    .re (item_acc), .raddr (AW'(left_w)), .rdata (spin_l)
  );
  isu_spin_ram #(.DEPTH(MAX_SPINS), .AW(AW)) u_ram_c (
    .clk (clk), .we (ram_we), .waddr (ram_waddr), .wdata (ram_wdata),
    .re (item_acc), .raddr (AW'(site_w)), .rdata (spin_c)
  );
  isu_spin_ram #(.DEPTH(MAX_SPINS), .AW(AW)) u_ram_r (
    .clk (clk), .we (ram_we), .waddr (ram_waddr), .wdata (ram_wdata),
    .re (item_acc), .raddr (AW'(right_w)), .rdata (spin_r)
  );

  isu_decide u_decide (
    .op_write (s1_write),
    .rnd      (s1_rnd),
    .wval     (s1_wval),
    .spin_l   (spin_l),
    .spin_c   (spin_c),
    .spin_r   (spin_r),
    .regs     (regs),
    .dec      (dec)
  );

  logic                                out_valid;
  isu_pkg::result_t                    out_data;
  logic signed [isu_pkg::SUM_W-1:0]    mag;
  logic signed [isu_pkg::SUM_W-1:0]    bond;
  logic signed [isu_pkg::SUM_W-1:0]    mag_next;
  logic signed [isu_pkg::SUM_W-1:0]    bond_next;

  assign s1_adv      = s1_valid && (!out_valid || results.ready);
  assign items.ready = !fill.busy && (!s1_valid || s1_adv);

  assign ram_we    = fill.busy || (s1_adv && !s1_err && dec.changed);
  assign ram_waddr = fill.busy ? fill_addr : s1_site;
  assign ram_wdata = fill.busy ? 1'b1 : dec.spin_new;

  assign mag_next  = s1_err ? mag  : mag  + dec.mag_delta;
  assign bond_next = s1_err ? bond : bond + dec.bond_delta;

  assign results.valid   = out_valid;
  assign results.payload = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      mag       <= RESET_SUM;
      bond      <= RESET_SUM;
    end else begin
      if (item_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (fill.restart) begin
        mag  <= isu_pkg::SUM_W'(regs.spin_count);
        bond <= isu_pkg::SUM_W'(regs.spin_count);
      end else if (s1_adv) begin
        mag  <= mag_next;
        bond <= bond_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      s1_write <= (items.payload.operation == isu_pkg::OP_WRITE);
      s1_err   <= (site_w >= regs.spin_count);
      s1_rnd   <= items.payload.random_fraction;
      s1_wval  <= items.payload.spin_value;
      s1_site  <= AW'(site_w);
    end
    if (s1_adv) begin
      out_data.spin_after    <= !s1_err && dec.spin_new;
      out_data.changed       <= !s1_err && dec.changed;
      out_data.site_error    <= s1_err;
      out_data.magnetization <= mag_next;
      out_data.bond_sum      <= bond_next;
    end
  end

endmodule

`default_nettype wire

>>> verif/tb_ising_1d_spin_update_unit.sv
// ----------------------------------------------------------------------------
// tb_ising_1d_spin_update_unit
// Self-checking bench for the 1D Ising spin update unit: directed writes and
// updates at the ring edges and threshold boundaries, then randomized phases
// over several ring lengths and threshold tables. A local spin-ring predictor
// supplies the expected result of every item.
// ----------------------------------------------------------------------------
module tb_ising_1d_spin_update_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import isu_pkg::*;

  localparam int RING_MAX = 1024;

  logic clk;
  logic rst;

  isu_stream_if #(.payload_t(item_t))   item_ch ();
  isu_stream_if #(.payload_t(result_t)) result_ch ();
  isu_stream_if #(.payload_t(cfg_wr_t)) cfg_ch ();

  ising_1d_spin_update_unit #(.MAX_SPINS(RING_MAX)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  // predictor state
  bit               spin_mem [RING_MAX];
  int               mag_total;
  int               bond_total;
  bit               use_metro;
  int               ring_len;
  logic [THR_W-1:0] thr_tab [2][3];

  item_t   queued_items [$];
  result_t pending_results [$];
  int      mismatches;
  logic    item_fire;
  int      tx_idle_pct;
  int      rx_idle_pct;
  bit      rx_hold_req;
  int      rx_hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void fill_spin_ring();
    for (int i = 0; i < RING_MAX; i++) spin_mem[i] = 1'b1;
    mag_total  = ring_len;
    bond_total = ring_len;
  endfunction

  function automatic void reset_ring_model();
    use_metro = 1'b1;
    ring_len  = DEF_SPINS;
    for (int a = 0; a < 2; a++)
      for (int b = 0; b < 3; b++) thr_tab[a][b] = THR_SAT;
    fill_spin_ring();
  endfunction

  function automatic void apply_reg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    logic [THR_W-1:0] t;
    int               n;
    t = (val > THR_SAT) ? THR_SAT : val;
    case (idx)
      REG_USE_METROPOLIS: use_metro = val[0];
      REG_SPIN_COUNT: begin
        n = val[COUNT_W-1:0];
        ring_len = (n < 3) ? 3 : ((n > RING_MAX) ? RING_MAX : n);
        fill_spin_ring();
      end
      REG_THR_UP_M2: thr_tab[1][NBR_MINUS2] = t;
      REG_THR_UP_Z:  thr_tab[1][NBR_ZERO]   = t;
      REG_THR_UP_P2: thr_tab[1][NBR_PLUS2]  = t;
      REG_THR_DN_M2: thr_tab[0][NBR_MINUS2] = t;
      REG_THR_DN_Z:  thr_tab[0][NBR_ZERO]   = t;
      REG_THR_DN_P2: thr_tab[0][NBR_PLUS2]  = t;
      default: ;
    endcase
  endfunction

  function automatic result_t predict_spin_update(item_t it);
    result_t          r;
    int               s, left, right, nsum, delta;
    bit               old, nw;
    logic [THR_W-1:0] t;
    r = '0;
    s = it.site;
    if (s >= ring_len) begin
      r.site_error = 1'b1;
    end else begin
      left  = (s == 0) ? ring_len - 1 : s - 1;
      right = (s + 1 == ring_len) ? 0 : s + 1;
      nsum  = (spin_mem[left] ? 1 : -1) + (spin_mem[right] ? 1 : -1);
      old   = spin_mem[s];
      if (op_t'(it.operation) == OP_WRITE) begin
        nw = it.spin_value;
      end else begin
        t = thr_tab[old][(nsum + 2) / 2];
        if (use_metro) nw = ({1'b0, it.random_fraction} <= t) ? !old : old;
        else nw = ({1'b0, it.random_fraction} < t);
      end
      if (nw != old) begin
        delta       = nw ? 2 : -2;
        spin_mem[s] = nw;
        mag_total  += delta;
        bond_total += delta * nsum;
        r.changed   = 1'b1;
      end
      r.spin_after = nw;
    end
    r.magnetization = mag_total[SUM_W-1:0];
    r.bond_sum      = bond_total[SUM_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // transactions in, predictions out, results checked in order
  always @(posedge clk) begin
    result_t want;
    result_t got;
    item_fire <= !rst && item_ch.valid && item_ch.ready;
    if (!rst && item_ch.valid && item_ch.ready)
      pending_results.push_back(predict_spin_update(item_ch.payload));
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = result_ch.payload;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, spin_after", got.spin_after, -1);
      end else begin
        want = pending_results.pop_front();
        if (got.spin_after !== want.spin_after)
          report_mismatch("spin_after", got.spin_after, want.spin_after);
        if (got.changed !== want.changed)
          report_mismatch("changed", got.changed, want.changed);
        if (got.site_error !== want.site_error)
          report_mismatch("site_error", got.site_error, want.site_error);
        if (got.magnetization !== want.magnetization)
          report_mismatch("magnetization", got.magnetization, want.magnetization);
        if (got.bond_sum !== want.bond_sum)
          report_mismatch("bond_sum", got.bond_sum, want.bond_sum);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || item_fire) begin
      if (queued_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        item_ch.payload <= queued_items.pop_front();
        item_ch.valid   <= 1'b1;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // result side: random back-pressure plus one long hold-off when requested
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (rx_hold_req) begin
      rx_hold_req  = 1'b0;
      rx_hold_left = 300;
      result_ch.ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= '{index: idx, data: val};
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg_write(idx, val);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (queued_items.size() != 0 || item_ch.valid || pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic item_t make_item(op_t op, int s, logic [RAND_W-1:0] rnd, bit val);
    item_t it;
    it.operation       = op;
    it.site            = s[SITE_W-1:0];
    it.random_fraction = rnd;
    it.spin_value      = val;
    return it;
  endfunction

  function automatic logic [THR_W-1:0] draw_threshold();
    logic [RAND_W-1:0] low;
    low = $urandom;
    case ($urandom_range(5))
      0: return '0;
      1: return THR_SAT;
      2: return {1'b1, (low == 0) ? 32'd1 : low};  // saturates
      default: return {1'b0, low};
    endcase
  endfunction

  // biased toward the exact thresholds so the <= / < boundary gets hit
  function automatic logic [RAND_W-1:0] draw_fraction();
    logic [THR_W-1:0] t;
    t = thr_tab[$urandom_range(1)][$urandom_range(2)];
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return t[RAND_W-1:0];
      3: return t[RAND_W-1:0] - 1;
      4: return t[RAND_W-1:0] + 1;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random_items(int n);
    int s;
    for (int k = 0; k < n; k++) begin
      if (ring_len == RING_MAX || $urandom_range(99) < 85) s = $urandom_range(ring_len - 1);
      else s = $urandom_range(RING_MAX - 1, ring_len);
      queued_items.push_back(make_item(($urandom_range(99) < 70) ? OP_UPDATE : OP_WRITE,
                                       s, draw_fraction(), $urandom_range(1)));
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] raw_count;
    rst             = 1'b1;
    item_ch.valid   = 1'b0;
    item_ch.payload = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.payload  = '0;
    mismatches      = 0;
    item_fire       = 1'b0;
    tx_idle_pct     = 24;
    rx_idle_pct     = 24;
    rx_hold_req     = 1'b0;
    rx_hold_left    = 0;
    reset_ring_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full ring, Metropolis, every threshold saturated: updates always flip
    queued_items.push_back(make_item(OP_UPDATE, 0, 32'h0, 1'b0));
    queued_items.push_back(make_item(OP_UPDATE, 1023, 32'hFFFF_FFFF, 1'b1));
    queued_items.push_back(make_item(OP_WRITE, 1, 32'h0, 1'b0));
    queued_items.push_back(make_item(OP_WRITE, 1, 32'hFFFF_FFFF, 1'b0));
    queued_items.push_back(make_item(OP_WRITE, 512, 32'h1234_5678, 1'b1));
    queued_items.push_back(make_item(OP_UPDATE, 1, 32'h5555_5555, 1'b0));
    wait_drained();

    // short ring, mixed thresholds incl. zero, exact half and above-saturation
    write_reg(REG_SPIN_COUNT, 33'd5);
    write_reg(REG_THR_UP_M2, 33'h0);
    write_reg(REG_THR_UP_Z, 33'h0_8000_0000);
    write_reg(REG_THR_UP_P2, 33'h1_FFFF_FFFF);
    write_reg(REG_THR_DN_M2, THR_SAT);
    write_reg(REG_THR_DN_Z, 33'h0_8000_0000);
    write_reg(REG_THR_DN_P2, 33'h0_FFFF_FFFF);
    queued_items.push_back(make_item(OP_UPDATE, 2, 32'h0, 1'b0));
    queued_items.push_back(make_item(OP_UPDATE, 5, 32'h0, 1'b1));     // out of range
    queued_items.push_back(make_item(OP_WRITE, 1023, 32'h0, 1'b0));   // out of range
    queued_items.push_back(make_item(OP_WRITE, 4, 32'h0, 1'b0));
    queued_items.push_back(make_item(OP_UPDATE, 0, 32'h8000_0000, 1'b0));
    queued_items.push_back(make_item(OP_UPDATE, 3, 32'h8000_0001, 1'b0));
    queued_items.push_back(make_item(OP_UPDATE, 2, 32'hFFFF_FFFF, 1'b0));
    wait_drained();

    // heat bath: strict compare at the threshold
    write_reg(REG_USE_METROPOLIS, 33'd0);
    queued_items.push_back(make_item(OP_UPDATE, 1, 32'h8000_0000, 1'b0));
    queued_items.push_back(make_item(OP_UPDATE, 1, 32'h7FFF_FFFF, 1'b0));
    queued_items.push_back(make_item(OP_UPDATE, 4, 32'hFFFF_FFFF, 1'b0));
    queued_items.push_back(make_item(OP_UPDATE, 0, 32'h0, 1'b1));
    wait_drained();

    // ring length below minimum counts as three
    write_reg(REG_SPIN_COUNT, 33'd0);
    queued_items.push_back(make_item(OP_UPDATE, 2, 32'h0, 1'b0));
    queued_items.push_back(make_item(OP_WRITE, 3, 32'h0, 1'b0));
    queued_items.push_back(make_item(OP_WRITE, 0, 32'h0, 1'b0));
    wait_drained();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: raw_count = 33'd2047;  // clamps to the maximum
        1: raw_count = 33'd1;
        5: raw_count = 33'd1024;
        4: raw_count = $urandom_range(64, 13);
        6: raw_count = $urandom_range(6, 3);
        default: raw_count = $urandom_range(12, 3);
      endcase
      write_reg(REG_USE_METROPOLIS, $urandom_range(1));
      write_reg(REG_SPIN_COUNT, raw_count);
      write_reg(REG_THR_UP_M2, draw_threshold());
      write_reg(REG_THR_UP_Z, draw_threshold());
      write_reg(REG_THR_UP_P2, draw_threshold());
      write_reg(REG_THR_DN_M2, draw_threshold());
      write_reg(REG_THR_DN_Z, draw_threshold());
      write_reg(REG_THR_DN_P2, draw_threshold());
      tx_idle_pct = (ph == 2) ? 0 : 24;
      rx_idle_pct = (ph == 2) ? 0 : 24;
      if (ph == 4) begin
        // sender stops until everything outstanding has come back
        queue_random_items(32);
        wait_drained();
        queue_random_items(33);
      end else begin
        queue_random_items(65);
        // result side holds off while items keep coming, so the input stalls
        if (ph == 3) rx_hold_req = 1'b1;
      end
      wait_drained();
    end

    tx_idle_pct = 24;
    rx_idle_pct = 24;
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
